// ===== rtl/ecgmwc_pkg.sv =====
// ---------------------------------------------------------------------------
// ecgmwc_pkg: shared types and constants of the ECG median wave classifier
// Field widths, scaling constants, register indexes, event codes.
// ---------------------------------------------------------------------------
package ecgmwc_pkg;

  localparam int RAW_W        = 16;
  localparam int STAMP_W      = 31;
  localparam int MV_W         = 12;
  localparam int MS_W         = 16;
  localparam int PROD_W       = RAW_W + MV_W;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 16;
  localparam int WINDOW_LEN_DEF = 5;
  localparam int QUEUE_DEPTH  = 4;

  localparam logic [MV_W-1:0] MV_FULL = 12'd3300;

  localparam logic [MV_W-1:0] QRS_THR_RST = 12'd500;
  localparam logic [MV_W-1:0] P_THR_RST   = 12'd300;
  localparam logic [MV_W-1:0] T_THR_RST   = 12'd250;
  localparam logic [MS_W-1:0] REFR_RST    = 16'd200;
  localparam logic [MS_W-1:0] T_DELAY_RST = 16'd100;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_QRS_THR = 3'd0,
    CFG_P_THR   = 3'd1,
    CFG_T_THR   = 3'd2,
    CFG_REFR    = 3'd3,
    CFG_T_DELAY = 3'd4
  } cfg_idx_t;

  typedef enum logic [1:0] {
    EV_BASELINE = 2'd0,
    EV_QRS      = 2'd1,
    EV_P        = 2'd2,
    EV_T        = 2'd3
  } event_t;

  // one filtered item on its way from the front to the back
  typedef struct packed {
    logic [MV_W-1:0]    mv;
    logic [STAMP_W-1:0] stamp;
  } q_entry_t;

  typedef struct packed {
    logic [MV_W-1:0] qrs_thr;
    logic [MV_W-1:0] p_thr;
    logic [MV_W-1:0] t_thr;
    logic [MS_W-1:0] refr;
    logic [MS_W-1:0] t_delay;
  } cfg_regs_t;

endpackage

// ===== rtl/ecgmwc_if.sv =====
// ---------------------------------------------------------------------------
// ecgmwc_in_if / ecgmwc_out_if: sample and result channels
// Valid/ready channels carrying the sample and the classified result.
// ---------------------------------------------------------------------------
interface ecgmwc_in_if import ecgmwc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [RAW_W-1:0]   raw_sample;
  logic [STAMP_W-1:0] time_ms;

  modport source (output valid, output raw_sample, output time_ms, input ready);
  modport sink   (input valid, input raw_sample, input time_ms, output ready);
endinterface

interface ecgmwc_out_if import ecgmwc_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [MV_W-1:0] filtered_mv;
  logic [1:0]      event_class;

  modport source (output valid, output filtered_mv, output event_class, input ready);
  modport sink   (input valid, input filtered_mv, input event_class, output ready);
endinterface

// ===== rtl/ecgmwc_front.sv =====
// ---------------------------------------------------------------------------
// ecgmwc_front: scaling and median stage
// Scales each sample to millivolts, writes it into the window ring and
// forms the median of the window by rank counting.
// ---------------------------------------------------------------------------
module ecgmwc_front import ecgmwc_pkg::*; #(
  parameter int WINDOW_LEN = WINDOW_LEN_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [RAW_W-1:0]   in_raw,
  input  logic [STAMP_W-1:0] in_stamp,
  output logic               push_valid,
  output q_entry_t           push_data,
  input  logic               q_full
);

  localparam int SLOT_W = $clog2(WINDOW_LEN);
  localparam int RANK_W = $clog2(WINDOW_LEN);
  localparam int MID    = WINDOW_LEN / 2;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW_LEN - 1);

  logic                s1_v_r, s1_v_nxt;
  logic [PROD_W-1:0]   prod_r;
  logic [STAMP_W-1:0]  s1_stamp_r;
  logic                s2_v_r, s2_v_nxt;
  logic [STAMP_W-1:0]  s2_stamp_r;
  logic [MV_W-1:0]     win_r [WINDOW_LEN];
  logic [SLOT_W-1:0]   slot_r, slot_nxt;

  logic                adv;
  logic [PROD_W:0]     div_sum;
  logic [MV_W-1:0]     mv;
  logic [MV_W-1:0]     med;
  logic [RANK_W-1:0]   rank;

  assign adv      = !s2_v_r || !q_full;
  assign in_ready = adv;
  assign s1_v_nxt = in_valid;
  assign s2_v_nxt = s1_v_r;
  assign slot_nxt = (slot_r == LAST_SLOT) ? '0 : slot_r + 1'b1;

  // x / 65535 as (x + (x >> 16) + 1) >> 16, exact for this product range
  assign div_sum = {1'b0, prod_r} + {{(RAW_W + 1){1'b0}}, prod_r[PROD_W-1:RAW_W]}
                   + {{PROD_W{1'b0}}, 1'b1};
  assign mv      = div_sum[PROD_W-1:RAW_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      slot_r <= '0;
      for (int k = 0; k < WINDOW_LEN; k++) win_r[k] <= '0;
    end else if (adv) begin
      s1_v_r <= s1_v_nxt;
      s2_v_r <= s2_v_nxt;
      if (s1_v_r) begin
        win_r[slot_r] <= mv;
        slot_r        <= slot_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prod_r     <= {{MV_W{1'b0}}, in_raw} * {{RAW_W{1'b0}}, MV_FULL};
      s1_stamp_r <= in_stamp;
      s2_stamp_r <= s1_stamp_r;
    end
  end

  // median: the entry whose rank (ties broken by position) is the middle one
  always_comb begin
    med  = '0;
    rank = '0;
    for (int i = 0; i < WINDOW_LEN; i++) begin
      rank = '0;
      for (int j = 0; j < WINDOW_LEN; j++) begin
        if (j != i) begin
          if (win_r[j] < win_r[i] || (win_r[j] == win_r[i] && j < i)) begin
            rank = rank + 1'b1;
          end
        end
      end
      if (rank == RANK_W'(MID)) begin
        med = win_r[i];
      end
    end
  end

  assign push_valid      = s2_v_r;
  assign push_data.mv    = med;
  assign push_data.stamp = s2_stamp_r;

endmodule

// ===== rtl/ecgmwc_queue.sv =====
// ---------------------------------------------------------------------------
// ecgmwc_queue: short queue between front and back
// Small register queue so the front and back stall independently.
// ---------------------------------------------------------------------------
module ecgmwc_queue import ecgmwc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  q_entry_t push_data,
  output logic     full,
  output logic     pop_valid,
  output q_entry_t pop_data,
  input  logic     pop_ready
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

  q_entry_t         mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full      = (cnt_r == FULL_CNT);
  assign pop_valid = (cnt_r != '0);
  assign pop_data  = mem_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop_valid && pop_ready;

  assign wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
  assign rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) cnt_nxt = cnt_r + 1'b1;
    else if (!do_push && do_pop) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_push) wr_ptr_r <= wr_ptr_nxt;
      if (do_pop)  rd_ptr_r <= rd_ptr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_data;
  end

endmodule

// ===== rtl/ecgmwc_back.sv =====
// ---------------------------------------------------------------------------
// ecgmwc_back: wave classifier and result register
// Holds the threshold registers, classifies each median in priority
// order QRS, P, T, baseline, and drives the result register.
// ---------------------------------------------------------------------------
module ecgmwc_back import ecgmwc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  q_valid,
  input  q_entry_t              q_data,
  output logic                  q_pop,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [MV_W-1:0]       out_mv,
  output logic [1:0]            out_class
);

  cfg_regs_t          cfg_r;
  logic [STAMP_W-1:0] last_qrs_r, last_qrs_nxt;
  logic               qrs_seen_r, qrs_seen_nxt;
  logic               out_v_r;
  logic [MV_W-1:0]    out_mv_r;
  event_t             out_ev_r, ev_nxt;

  logic [STAMP_W:0]   elapsed;
  logic               el_pos;
  logic               refr_ok, delay_ok;

  assign q_pop = q_valid && (!out_v_r || out_ready);

  // signed difference: a backward timestamp passes neither time test
  assign elapsed  = {1'b0, q_data.stamp} - {1'b0, last_qrs_r};
  assign el_pos   = !elapsed[STAMP_W];
  assign refr_ok  = el_pos && (elapsed[STAMP_W-1:0] > {{(STAMP_W - MS_W){1'b0}}, cfg_r.refr});
  assign delay_ok = el_pos
                    && (elapsed[STAMP_W-1:0] > {{(STAMP_W - MS_W){1'b0}}, cfg_r.t_delay});

  always_comb begin
    ev_nxt       = EV_BASELINE;
    last_qrs_nxt = last_qrs_r;
    qrs_seen_nxt = qrs_seen_r;
    if (q_data.mv > cfg_r.qrs_thr && refr_ok) begin
      ev_nxt       = EV_QRS;
      last_qrs_nxt = q_data.stamp;
      qrs_seen_nxt = 1'b1;
    end else if (q_data.mv > cfg_r.p_thr && !qrs_seen_r) begin
      ev_nxt = EV_P;
    end else if (qrs_seen_r && q_data.mv > cfg_r.t_thr && delay_ok) begin
      ev_nxt       = EV_T;
      qrs_seen_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.qrs_thr <= QRS_THR_RST;
      cfg_r.p_thr   <= P_THR_RST;
      cfg_r.t_thr   <= T_THR_RST;
      cfg_r.refr    <= REFR_RST;
      cfg_r.t_delay <= T_DELAY_RST;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_QRS_THR: cfg_r.qrs_thr <= cfg_data[MV_W-1:0];
        CFG_P_THR:   cfg_r.p_thr   <= cfg_data[MV_W-1:0];
        CFG_T_THR:   cfg_r.t_thr   <= cfg_data[MV_W-1:0];
        CFG_REFR:    cfg_r.refr    <= cfg_data[MS_W-1:0];
        CFG_T_DELAY: cfg_r.t_delay <= cfg_data[MS_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_qrs_r <= '0;
      qrs_seen_r <= 1'b0;
      out_v_r    <= 1'b0;
    end else begin
      if (q_pop) begin
        last_qrs_r <= last_qrs_nxt;
        qrs_seen_r <= qrs_seen_nxt;
        out_v_r    <= 1'b1;
      end else if (out_ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_mv_r <= q_data.mv;
      out_ev_r <= ev_nxt;
    end
  end

  assign out_valid = out_v_r;
  assign out_mv    = out_mv_r;
  assign out_class = out_ev_r;

endmodule

// ===== rtl/ecg_median_wave_classifier.sv =====
// ---------------------------------------------------------------------------
// ecg_median_wave_classifier: ECG median filter and wave classifier
// Scales converter samples to millivolts, takes the median of a sliding
// window and reports QRS, P wave, T wave or baseline for each sample.
// ---------------------------------------------------------------------------
//   channel  dir  handshake      payload
//   in_ch    in   valid/ready    raw_sample[15:0], time_ms[30:0]
//   out_ch   out  valid/ready    filtered_mv[11:0], event_class[1:0]
//   cfg_*    in   cfg_we only    cfg_index[2:0], cfg_data[15:0]
//
// one item per cycle sustained while neither the queue nor out_ch stalls;
// each item is registered as its product, then divided and written to
// the window, its median pushed into the queue, then classified
// the front stalls only when the four-entry queue is full, the back only
// when out_ch is not ready; rst_n is synchronous and clears the window,
// the QRS history and the threshold registers to their defaults
module ecg_median_wave_classifier import ecgmwc_pkg::*; #(
  parameter int WINDOW_LEN = WINDOW_LEN_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  ecgmwc_in_if.sink             in_ch,
  ecgmwc_out_if.source          out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic     push_valid, q_full, q_valid, q_pop;
  q_entry_t push_data, q_data;

  ecgmwc_front #(.WINDOW_LEN(WINDOW_LEN)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_raw     (in_ch.raw_sample),
    .in_stamp   (in_ch.time_ms),
    .push_valid (push_valid),
    .push_data  (push_data),
    .q_full     (q_full)
  );

  ecgmwc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push_valid),
    .push_data (push_data),
    .full      (q_full),
    .pop_valid (q_valid),
    .pop_data  (q_data),
    .pop_ready (q_pop)
  );

  ecgmwc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_mv    (out_ch.filtered_mv),
    .out_class (out_ch.event_class)
  );

endmodule

// ===== rtl/ecgmwc_checker.sv =====
// ---------------------------------------------------------------------------
// ecgmwc_checker: port-level checks on the classifier
// Watches the channel ports and checks item flow and result range.
// ---------------------------------------------------------------------------
module ecgmwc_checker import ecgmwc_pkg::*; (
  input logic            clk,
  input logic            rst_n,
  input logic            in_valid,
  input logic            in_ready,
  input logic            out_valid,
  input logic            out_ready,
  input logic [MV_W-1:0] out_mv
);

  // front holds two items, the queue four, the result register one
  localparam logic [3:0] MAX_INFLIGHT = 4'd7;

  logic [3:0] inflight_r, inflight_nxt;
  logic       in_acc, out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  always_comb begin
    inflight_nxt = inflight_r;
    if (in_acc && !out_acc) inflight_nxt = inflight_r + 1'b1;
    else if (!in_acc && out_acc) inflight_nxt = inflight_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) inflight_r <= '0;
    else inflight_r <= inflight_nxt;
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before it was taken");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc |-> (inflight_r != '0))
    else $error("result delivered with no item outstanding");

  a_inflight_bound: assert property (@(posedge clk) disable iff (!rst_n)
    inflight_r <= MAX_INFLIGHT)
    else $error("more items in flight than the pipeline can hold");

  a_mv_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_mv <= MV_FULL))
    else $error("filtered value above full scale");

endmodule

bind ecg_median_wave_classifier ecgmwc_checker u_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_mv    (out_ch.filtered_mv)
);

// ===== bench/ecg_median_wave_classifier_tb.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// ecg_median_wave_classifier_tb: self-checking bench for the ECG classifier
// Drives samples through a valid/ready channel under varying stalls and
// register settings, predicts the median and the wave class of every item
// and compares each result with the oldest prediction.
// ---------------------------------------------------------------------------
module ecg_median_wave_classifier_tb;
  import ecgmwc_pkg::*;

  localparam int          CYCLE_LIMIT = 200000;
  localparam int          NUM_ROWS    = 20;
  localparam int          NUM_PHASES  = 6;
  localparam int          PHASE_ITEMS = 125;
  localparam int unsigned ADC_SPAN    = 65535;
  localparam int unsigned MV_TOP      = 3300;

  typedef struct packed {
    logic [MV_W-1:0] mv;
    event_t          ev;
  } beat_t;

  typedef struct packed {
    logic [RAW_W-1:0]   raw;
    logic [STAMP_W-1:0] stamp;
    logic               typed;
    logic [MV_W-1:0]    mv;
    event_t             ev;
  } stim_row_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  ecgmwc_in_if  in_ch ();
  ecgmwc_out_if out_ch ();

  ecg_median_wave_classifier dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // predictor state
  logic [MV_W-1:0]    win_mv [WINDOW_LEN_DEF];
  int unsigned        win_pos;
  logic [STAMP_W-1:0] last_qrs;
  logic               qrs_armed;
  logic [MV_W-1:0]    thr_qrs;
  logic [MV_W-1:0]    thr_p;
  logic [MV_W-1:0]    thr_t;
  logic [MS_W-1:0]    refr_ms;
  logic [MS_W-1:0]    tdelay_ms;

  beat_t expected_beats [$];
  int    mismatch_count;
  int    cycle_count;
  int    send_idle_pct;
  int    recv_idle_pct;

  // start-up zeros, then time going backwards with a QRS pending
  stim_row_t dir_rows [NUM_ROWS] = '{
    '{16'd0,     31'h7FFFFFFF, 1'b1, 12'd0,    EV_BASELINE},
    '{16'd65535, 31'd10,       1'b1, 12'd0,    EV_BASELINE},
    '{16'd65535, 31'd20,       1'b1, 12'd0,    EV_BASELINE},
    '{16'd65535, 31'd30,       1'b1, 12'd3300, EV_P},
    '{16'd65535, 31'd250,      1'b1, 12'd3300, EV_QRS},
    '{16'd65535, 31'd300,      1'b1, 12'd3300, EV_BASELINE},
    '{16'd65535, 31'd351,      1'b1, 12'd3300, EV_T},
    '{16'd65535, 31'd451,      1'b1, 12'd3300, EV_QRS},
    '{16'd65535, 31'd10,       1'b1, 12'd3300, EV_BASELINE},
    '{16'd0,     31'd600,      1'b0, 12'd0,    EV_BASELINE},
    '{16'd0,     31'd610,      1'b0, 12'd0,    EV_BASELINE},
    '{16'd0,     31'd620,      1'b0, 12'd0,    EV_BASELINE},
    '{16'd1,     31'd630,      1'b0, 12'd0,    EV_BASELINE},
    '{16'd19860, 31'd640,      1'b0, 12'd0,    EV_BASELINE},
    '{16'd32768, 31'd650,      1'b0, 12'd0,    EV_BASELINE},
    '{16'd21845, 31'd650,      1'b0, 12'd0,    EV_BASELINE},
    '{16'd43690, 31'd900,      1'b0, 12'd0,    EV_BASELINE},
    '{16'd65534, 31'd1100,     1'b0, 12'd0,    EV_BASELINE},
    '{16'd65534, 31'd1300,     1'b0, 12'd0,    EV_BASELINE},
    '{16'd65534, 31'd1500,     1'b0, 12'd0,    EV_BASELINE}
  };

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic beat_t predict_event(input logic [RAW_W-1:0] raw,
                                          input logic [STAMP_W-1:0] stamp);
    int unsigned sorted [WINDOW_LEN_DEF];
    int unsigned mv;
    int unsigned hold;
    int i;
    int j;
    longint elapsed;
    beat_t res;
    mv = (32'(raw) * MV_TOP) / ADC_SPAN;
    win_mv[win_pos] = mv[MV_W-1:0];
    win_pos = (win_pos + 1) % WINDOW_LEN_DEF;
    for (i = 0; i < WINDOW_LEN_DEF; i++) sorted[i] = 32'(win_mv[i]);
    for (i = 0; i < WINDOW_LEN_DEF - 1; i++) begin
      for (j = 0; j < WINDOW_LEN_DEF - 1 - i; j++) begin
        if (sorted[j] > sorted[j+1]) begin
          hold = sorted[j];
          sorted[j] = sorted[j+1];
          sorted[j+1] = hold;
        end
      end
    end
    res.mv = sorted[WINDOW_LEN_DEF/2][MV_W-1:0];
    // signed difference, so a stamp going backwards fails both time tests
    elapsed = longint'(stamp) - longint'(last_qrs);
    if (res.mv > thr_qrs && elapsed > longint'(refr_ms)) begin
      last_qrs = stamp;
      qrs_armed = 1'b1;
      res.ev = EV_QRS;
    end else if (res.mv > thr_p && !qrs_armed) begin
      res.ev = EV_P;
    end else if (qrs_armed && res.mv > thr_t && elapsed > longint'(tdelay_ms)) begin
      qrs_armed = 1'b0;
      res.ev = EV_T;
    end else begin
      res.ev = EV_BASELINE;
    end
    return res;
  endfunction

  // smallest reading that scales to the given level
  function automatic logic [RAW_W-1:0] raw_for_mv(input int unsigned mv);
    int unsigned r;
    if (mv > MV_TOP) mv = MV_TOP;
    r = (mv * ADC_SPAN + MV_TOP - 1) / MV_TOP;
    if (r > ADC_SPAN) r = ADC_SPAN;
    return r[RAW_W-1:0];
  endfunction

  function automatic int unsigned near_level(input logic [MV_W-1:0] thr);
    int lvl;
    lvl = int'(thr) + int'($urandom_range(0, 6)) - 3;
    if (lvl < 0) lvl = 0;
    if (lvl > int'(MV_TOP)) lvl = MV_TOP;
    return lvl;
  endfunction

  task automatic set_idling(input int mode);
    case (mode)
      0: begin
        send_idle_pct = 16;
        recv_idle_pct = 53;
      end
      1: begin
        send_idle_pct = 53;
        recv_idle_pct = 16;
      end
      default: begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
    endcase
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    case (idx)
      CFG_QRS_THR: thr_qrs   = data[MV_W-1:0];
      CFG_P_THR:   thr_p     = data[MV_W-1:0];
      CFG_T_THR:   thr_t     = data[MV_W-1:0];
      CFG_REFR:    refr_ms   = data[MS_W-1:0];
      CFG_T_DELAY: tdelay_ms = data[MS_W-1:0];
      default: ;
    endcase
  endtask

  task automatic send_item(input logic [RAW_W-1:0] raw, input logic [STAMP_W-1:0] stamp,
                           input logic typed, input logic [MV_W-1:0] typed_mv,
                           input event_t typed_ev);
    beat_t res;
    if ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.raw_sample <= raw;
    in_ch.time_ms    <= stamp;
    do @(posedge clk); while (!in_ch.ready);
    res = predict_event(raw, stamp);
    if (typed) begin
      res.mv = typed_mv;
      res.ev = typed_ev;
    end
    expected_beats.push_back(res);
  endtask

  // hold the sender off until every result is back, then a few more cycles
  task automatic settle(input int extra);
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  always @(posedge clk) begin
    beat_t want;
    cycle_count = cycle_count + 1;
    out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_beats.size() == 0) begin
        $error("unexpected item: filtered_mv %0d event_class %0d",
               out_ch.filtered_mv, out_ch.event_class);
        mismatch_count++;
      end else begin
        want = expected_beats.pop_front();
        if (out_ch.filtered_mv !== want.mv) begin
          $error("filtered_mv: expected %0d, got %0d", want.mv, out_ch.filtered_mv);
          mismatch_count++;
        end
        if (out_ch.event_class !== want.ev) begin
          $error("event_class: expected %0d, got %0d", want.ev, out_ch.event_class);
          mismatch_count++;
        end
      end
    end
    if (cycle_count > CYCLE_LIMIT) begin
      $display("ecg_median_wave_classifier_tb NOT OK");
      $finish;
    end
  end

  initial begin
    int unsigned cur_ms;
    int unsigned run_mv;
    int unsigned run_left;
    int unsigned pick;
    logic [RAW_W-1:0] raw;
    mismatch_count = 0;
    cycle_count    = 0;
    for (int k = 0; k < WINDOW_LEN_DEF; k++) win_mv[k] = '0;
    win_pos   = 0;
    last_qrs  = '0;
    qrs_armed = 1'b0;
    thr_qrs   = QRS_THR_RST;
    thr_p     = P_THR_RST;
    thr_t     = T_THR_RST;
    refr_ms   = REFR_RST;
    tdelay_ms = T_DELAY_RST;
    set_idling(0);
    rst_n            <= 1'b0;
    cfg_we           <= 1'b0;
    cfg_index        <= '0;
    cfg_data         <= '0;
    in_ch.valid      <= 1'b0;
    in_ch.raw_sample <= '0;
    in_ch.time_ms    <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[r])
      send_item(dir_rows[r].raw, dir_rows[r].stamp, dir_rows[r].typed,
                dir_rows[r].mv, dir_rows[r].ev);

    cur_ms   = 2000;
    run_mv   = 0;
    run_left = 0;
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      settle(8);
      case (ph)
        1: begin
          write_reg(CFG_QRS_THR, 16'd0);
          write_reg(CFG_P_THR,   16'd0);
          write_reg(CFG_T_THR,   16'd0);
          write_reg(CFG_REFR,    16'd0);
          write_reg(CFG_T_DELAY, 16'd0);
        end
        2: begin
          // upper bits are dropped, leaving full scale
          write_reg(CFG_QRS_THR, 16'hFCE4);
          write_reg(CFG_P_THR,   16'h1CE4);
          write_reg(CFG_T_THR,   16'd3300);
          write_reg(CFG_REFR,    16'hFFFF);
          write_reg(CFG_T_DELAY, 16'hFFFF);
        end
        3: begin
          write_reg(CFG_QRS_THR, 16'($urandom_range(0, 65535)));
          write_reg(CFG_P_THR,   16'($urandom_range(0, 65535)));
          write_reg(CFG_T_THR,   16'($urandom_range(0, 65535)));
          write_reg(CFG_REFR,    16'($urandom_range(0, 600)));
          write_reg(CFG_T_DELAY, 16'($urandom_range(0, 400)));
        end
        default: begin
          write_reg(CFG_QRS_THR, 16'($urandom_range(1500, 2500)));
          write_reg(CFG_P_THR,   16'($urandom_range(600, 1200)));
          write_reg(CFG_T_THR,   16'($urandom_range(300, 900)));
          write_reg(CFG_REFR,    16'($urandom_range(100, 400)));
          write_reg(CFG_T_DELAY, 16'($urandom_range(50, 200)));
        end
      endcase
      // an index past the last register must change nothing
      write_reg(CFG_IDX_W'(CFG_T_DELAY) + CFG_IDX_W'($urandom_range(1, 3)),
                16'($urandom_range(0, 65535)));
      cfg_we <= 1'b0;
      set_idling(ph % 3);

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == 1 && n == 60) settle(0);
        // hold a level for a few items so the median follows it
        if (run_left == 0) begin
          pick = $urandom_range(0, 9);
          case (pick)
            0, 1:    run_mv = near_level(thr_qrs);
            2, 3:    run_mv = near_level(thr_p);
            4, 5:    run_mv = near_level(thr_t);
            6:       run_mv = 0;
            7:       run_mv = MV_TOP;
            default: run_mv = $urandom_range(0, MV_TOP);
          endcase
          run_left = $urandom_range(1, 7);
        end
        run_left--;
        raw = raw_for_mv(run_mv);
        if ($urandom_range(99) < 10) raw = 16'($urandom_range(0, 65535));
        pick = $urandom_range(0, 99);
        if (pick < 4) begin
          cur_ms = cur_ms - ((cur_ms < 500) ? cur_ms : $urandom_range(1, 500));
        end else if (pick < 14) begin
          cur_ms = cur_ms + $urandom_range(100, 70000);
        end else if (pick >= 20) begin
          cur_ms = cur_ms + $urandom_range(1, 60);
        end
        send_item(raw, STAMP_W'(cur_ms), 1'b0, '0, EV_BASELINE);
      end
    end

    settle(20);
    if (mismatch_count == 0) begin
      $display("ecg_median_wave_classifier_tb OK");
    end else begin
      $display("ecg_median_wave_classifier_tb NOT OK");
    end
    $finish;
  end

endmodule
